// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the vertex cache analyzer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define VFCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define VFCA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/vfca_pkg.sv -----
// Package: shared types and constants of the vertex cache analyzer.
`timescale 1ns / 1ps
`default_nettype none
package vfca_pkg;
  localparam int MaxCacheDepth = 64;
  localparam int SlotBits      = $clog2(MaxCacheDepth);
  localparam int DepthBits     = 7;
  localparam int IndexBits     = 32;

  localparam logic [1:0] CfgCacheDepth = 2'd0;
  localparam logic [1:0] CfgWarpLimit  = 2'd1;
  localparam logic [1:0] CfgBufLimit   = 2'd2;

  typedef struct packed {
    logic [31:0] vertex_a;
    logic [31:0] vertex_b;
    logic [31:0] vertex_c;
    logic        end_of_mesh;
  } item_t;

  typedef struct packed {
    logic [6:0]  cache_depth;
    logic [7:0]  warp_limit;
    logic [15:0] triangle_buffer_limit;
  } cfg_t;
endpackage
`default_nettype wire

// ----- hw/rtl/vfca_front.sv -----
// Front end: accepts triangle items and queues them for the cache engine.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vfca_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  vfca_pkg::item_t  in_item_i,
  output logic             head_valid_o,
  output vfca_pkg::item_t  head_item_o,
  input  wire              head_pop_i
);
  import vfca_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = head_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, head_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the accepted item in the write slot of the queue.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  `VFCA_ASSERT(a_pop_nonempty, head_pop_i |-> count_q != 2'd0, "pop from empty queue")
  `VFCA_ASSERT(a_push_not_full, push |-> count_q != 2'd2, "push into full queue")
  `VFCA_ASSERT(a_count_range, count_q != 2'd3, "queue count overflow")
endmodule
`default_nettype wire

// ----- hw/rtl/vfca_back.sv -----
// Back end: FIFO cache, one vertex per cycle unless stalled, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vfca_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  vfca_pkg::cfg_t   cfg_i,
  input  wire              head_valid_i,
  input  vfca_pkg::item_t  head_item_i,
  output logic             head_pop_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [1:0]       new_vertex_count_o,
  output logic             flush_done_o,
  output logic [31:0]      transformed_total_o,
  output logic [31:0]      warps_total_o,
  output logic             run_end_o
);
  import vfca_pkg::*;

  localparam logic [1:0] STEP_A = 2'd0;
  localparam logic [1:0] STEP_B = 2'd1;
  localparam logic [1:0] STEP_C = 2'd2;

  logic [IndexBits-1:0]     vert_q [MaxCacheDepth];
  logic [MaxCacheDepth-1:0] valid_q, valid_d, in_win;
  logic [MaxCacheDepth-1:0] match_a, match_b, match_c;
  logic [SlotBits-1:0]      slot_q, slot_d, age;
  logic [8:0]  warp_q, warp_d;
  logic [15:0] batch_q, batch_d;
  logic [31:0] miss_total_q, miss_total_d, warp_total_q, warp_total_d, warps_out;
  logic [1:0]  step_q, step_d, added_q, added_d, pre;
  logic        flushed_q, flushed_d;
  logic [DepthBits-1:0] depth_eff;
  logic        hit_a, hit_b, hit_c, flush, cur_miss, advance, out_load;
  logic [IndexBits-1:0] cur_vertex;
  logic        out_valid_q;
  logic [1:0]  out_cnt_q;
  logic        out_flush_q, out_end_q;
  logic [31:0] out_miss_q, out_warps_q;

  assign depth_eff = (cfg_i.cache_depth > DepthBits'(MaxCacheDepth)) ?
                     DepthBits'(MaxCacheDepth) : cfg_i.cache_depth;

  // Window of the last depth_eff insertions, then three parallel tag compares.
  always_comb begin
    for (int k = 0; k < MaxCacheDepth; k++) begin
      age        = slot_q - SlotBits'(1) - SlotBits'(k);
      in_win[k]  = valid_q[k] && ({1'b0, age} < depth_eff);
      match_a[k] = (vert_q[k] == head_item_i.vertex_a[IndexBits-1:0]);
      match_b[k] = (vert_q[k] == head_item_i.vertex_b[IndexBits-1:0]);
      match_c[k] = (vert_q[k] == head_item_i.vertex_c[IndexBits-1:0]);
    end
  end

  assign hit_a = |(in_win & match_a);
  assign hit_b = |(in_win & match_b);
  assign hit_c = |(in_win & match_c);
  assign pre   = 2'({1'b0, !hit_a} + {1'b0, !hit_b} + {1'b0, !hit_c});
  assign flush = (step_q == STEP_A) &&
                 (((cfg_i.triangle_buffer_limit != 16'd0) &&
                   (batch_q == cfg_i.triangle_buffer_limit)) ||
                  ((cfg_i.warp_limit != 8'd0) &&
                   (({1'b0, warp_q} + {8'd0, pre}) > {2'd0, cfg_i.warp_limit})));

  always_comb begin
    case (step_q)
      STEP_A:  begin cur_miss = flush || !hit_a; cur_vertex = head_item_i.vertex_a; end
      STEP_B:  begin cur_miss = !hit_b; cur_vertex = head_item_i.vertex_b; end
      STEP_C:  begin cur_miss = !hit_c; cur_vertex = head_item_i.vertex_c; end
      default: begin cur_miss = 1'b0; cur_vertex = head_item_i.vertex_a; end
    endcase
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign advance    = head_valid_i && ((step_q != STEP_C) || out_load);
  assign head_pop_o = advance && (step_q == STEP_C);

  always_comb begin
    valid_d      = valid_q;
    slot_d       = slot_q;
    warp_d       = warp_q;
    batch_d      = batch_q;
    miss_total_d = miss_total_q;
    warp_total_d = warp_total_q;
    added_d      = (step_q == STEP_A) ? 2'd0 : added_q;
    flushed_d    = (step_q == STEP_A) ? flush : flushed_q;
    step_d       = step_q;
    warps_out    = warp_total_q;
    if (advance) begin
      if (flush) begin
        if (warp_q != 9'd0) begin
          warp_total_d = (warp_total_d == '1) ? warp_total_d : warp_total_d + 32'd1;
        end
        warp_d  = 9'd0;
        batch_d = 16'd0;
        valid_d = '0;
        slot_d  = '0;
      end
      if (cur_miss) begin
        valid_d[slot_d] = 1'b1;
        slot_d          = slot_d + SlotBits'(1);
        added_d         = added_d + 2'd1;
        miss_total_d    = (miss_total_d == '1) ? miss_total_d : miss_total_d + 32'd1;
        warp_d          = (warp_d == 9'd511) ? warp_d : warp_d + 9'd1;
      end
      step_d = (step_q == STEP_C) ? STEP_A : step_q + 2'd1;
      if (step_q == STEP_C) begin
        batch_d   = (batch_d == 16'hFFFF) ? batch_d : batch_d + 16'd1;
        warps_out = warp_total_d;
        if (head_item_i.end_of_mesh && (warp_d != 9'd0) && (warps_out != '1)) begin
          warps_out = warps_out + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      slot_q       <= '0;
      warp_q       <= 9'd0;
      batch_q      <= 16'd0;
      miss_total_q <= 32'd0;
      warp_total_q <= 32'd0;
      step_q       <= STEP_A;
      added_q      <= 2'd0;
      flushed_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      added_q   <= added_d;
      flushed_q <= flushed_d;
      step_q    <= step_d;
      if (head_pop_o && head_item_i.end_of_mesh) begin
        // Drop all run state after the final triangle of a mesh.
        valid_q      <= '0;
        slot_q       <= '0;
        warp_q       <= 9'd0;
        batch_q      <= 16'd0;
        miss_total_q <= 32'd0;
        warp_total_q <= 32'd0;
      end else begin
        valid_q      <= valid_d;
        slot_q       <= slot_d;
        warp_q       <= warp_d;
        batch_q      <= batch_d;
        miss_total_q <= miss_total_d;
        warp_total_q <= warp_total_d;
      end
      if (head_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Insert the missing vertex at the post-flush write slot.
  always_ff @(posedge clk_i) begin
    if (advance && cur_miss) begin
      vert_q[flush ? SlotBits'(0) : slot_q] <= cur_vertex;
    end
    if (head_pop_o) begin
      out_cnt_q   <= added_d;
      out_flush_q <= flushed_d;
      out_miss_q  <= miss_total_d;
      out_warps_q <= warps_out;
      out_end_q   <= head_item_i.end_of_mesh;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign new_vertex_count_o  = out_cnt_q;
  assign flush_done_o        = out_flush_q;
  assign transformed_total_o = out_miss_q;
  assign warps_total_o       = out_warps_q;
  assign run_end_o           = out_end_q;

  `VFCA_ASSERT(a_mid_item_has_head, (step_q != STEP_A) |-> head_valid_i, "engine lost its item")
  `VFCA_ASSERT(a_pop_on_last_step, head_pop_o |-> (step_q == STEP_C), "pop before last vertex")
  `VFCA_ASSERT(a_end_clears, (head_pop_o && head_item_i.end_of_mesh) |=> (miss_total_q == 32'd0 && warp_total_q == 32'd0 && valid_q == '0), "end of mesh did not clear")
endmodule
`default_nettype wire

// ----- hw/rtl/vertex_fifo_cache_analyzer.sv -----
// Top level: FIFO post-transform vertex cache analyzer.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel (in_valid_i/in_ready_o) moves one triangle item: three
//   vertex indices and an end_of_mesh flag. Output channel
//   (out_valid_o/out_ready_i) returns one result item per triangle: misses
//   caused, flush flag, running miss and warp totals, and run_end.
//   Throughput: one vertex per cycle through the shared cache compare/insert
//   engine while an item is queued and, at its last vertex, the result
//   register can load; the cache window is checked against all 64 entries
//   in parallel. Steps a, b, c follow the queue; step c loads out_valid_o.
//   A two-item queue lets the front accept while the engine works, and a
//   result register lets the engine finish while the receiver stalls; when
//   the receiver stalls, the engine holds on its last vertex and the queue
//   fills, then in_ready_o drops.
//   Reset: cache empty, all counts zero, cache_depth 16, limits disabled.
//   No clearing pass is needed. Write configuration (cfg_we_i, cfg_idx_i,
//   cfg_data_i) only while idle; writes take effect at once.
module vertex_fifo_cache_analyzer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] vertex_a_i,
  input  wire  [31:0] vertex_b_i,
  input  wire  [31:0] vertex_c_i,
  input  wire         end_of_mesh_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  new_vertex_count_o,
  output logic        flush_done_o,
  output logic [31:0] transformed_total_o,
  output logic [31:0] warps_total_o,
  output logic        run_end_o
);
  import vfca_pkg::*;

  cfg_t  cfg_q;
  item_t in_item, head_item;
  logic  head_valid, head_pop;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cache_depth           <= 7'd16;
      cfg_q.warp_limit            <= 8'd0;
      cfg_q.triangle_buffer_limit <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCacheDepth: cfg_q.cache_depth           <= cfg_data_i[6:0];
        CfgWarpLimit:  cfg_q.warp_limit            <= cfg_data_i[7:0];
        CfgBufLimit:   cfg_q.triangle_buffer_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.vertex_a    = vertex_a_i;
  assign in_item.vertex_b    = vertex_b_i;
  assign in_item.vertex_c    = vertex_c_i;
  assign in_item.end_of_mesh = end_of_mesh_i;

  vfca_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .head_pop_i   (head_pop)
  );

  vfca_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .head_valid_i        (head_valid),
    .head_item_i         (head_item),
    .head_pop_o          (head_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .new_vertex_count_o  (new_vertex_count_o),
    .flush_done_o        (flush_done_o),
    .transformed_total_o (transformed_total_o),
    .warps_total_o       (warps_total_o),
    .run_end_o           (run_end_o)
  );
endmodule
`default_nettype wire

// ----- sim/vertex_fifo_cache_analyzer_tb.sv -----
// Testbench of the FIFO vertex cache analyzer: directed and random triangles checked against a local cache model.
`timescale 1ns / 1ps
module vertex_fifo_cache_analyzer_tb;
  import vfca_pkg::*;

  localparam int NumRandom = 700;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [1:0]  new_vertex_count;
    logic        flush_done;
    logic [31:0] transformed_total;
    logic [31:0] warps_total;
    logic        run_end;
  } tri_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CfgCacheDepth;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [31:0] vertex_a_i = '0, vertex_b_i = '0, vertex_c_i = '0;
  logic end_of_mesh_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, flush_done_o, run_end_o;
  logic [1:0] new_vertex_count_o;
  logic [31:0] transformed_total_o, warps_total_o;

  always #1 clk_i = ~clk_i;

  vertex_fifo_cache_analyzer DUT (.*);

  // Cache model state, mirrors the block after reset.
  logic [6:0]  depth_q = 7'd16;
  logic [7:0]  warp_lim_q = '0;
  logic [15:0] batch_lim_q = '0;
  logic [31:0] slot_vertex [MaxCacheDepth];
  logic        slot_valid [MaxCacheDepth];
  int unsigned write_slot, warp_fill, batch_fill;
  logic [31:0] miss_total, warp_total;

  item_t       pending_tris [$];
  tri_result_t expected_results [$];
  int unsigned mismatches = 0, results_seen = 0, flushes_seen = 0, meshes_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0, out_gap = 0;
  bit          stim_done = 0;

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_cache();
    for (int k = 0; k < MaxCacheDepth; k++) slot_valid[k] = 1'b0;
    write_slot = 0;
  endfunction

  function automatic void clear_mesh();
    clear_cache();
    warp_fill = 0;
    batch_fill = 0;
    miss_total = '0;
    warp_total = '0;
  endfunction

  function automatic bit is_cached(logic [31:0] v);
    int unsigned d, s;
    d = (depth_q > MaxCacheDepth) ? MaxCacheDepth : depth_q;
    for (int unsigned k = 0; k < d; k++) begin
      s = (write_slot + 2 * MaxCacheDepth - 1 - k) % MaxCacheDepth;
      if (slot_valid[s] && slot_vertex[s] == v) return 1;
    end
    return 0;
  endfunction

  // Advance the cache model by one triangle and return its result.
  function automatic tri_result_t process_triangle(item_t t);
    tri_result_t r;
    logic [31:0] v [3];
    int unsigned pre, added;
    v[0] = t.vertex_a; v[1] = t.vertex_b; v[2] = t.vertex_c;
    pre = 0; added = 0;
    r = '0;
    for (int j = 0; j < 3; j++) if (!is_cached(v[j])) pre++;
    if ((batch_lim_q != 0 && batch_fill == batch_lim_q) ||
        (warp_lim_q != 0 && warp_fill + pre > warp_lim_q)) begin
      if (warp_fill > 0 && warp_total != '1) warp_total++;
      warp_fill = 0;
      batch_fill = 0;
      clear_cache();
      r.flush_done = 1'b1;
    end
    for (int j = 0; j < 3; j++) begin
      if (!is_cached(v[j])) begin
        slot_vertex[write_slot] = v[j];
        slot_valid[write_slot] = 1'b1;
        write_slot = (write_slot + 1) % MaxCacheDepth;
        added++;
        if (miss_total != '1) miss_total++;
        if (warp_fill < 511) warp_fill++;
      end
    end
    if (batch_fill < 65535) batch_fill++;
    r.new_vertex_count = added[1:0];
    r.transformed_total = miss_total;
    r.warps_total = warp_total;
    if (t.end_of_mesh && warp_fill > 0 && warp_total != '1) r.warps_total = warp_total + 1;
    r.run_end = t.end_of_mesh;
    if (t.end_of_mesh) clear_mesh();
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  // Driver: present queued triangles, hold each until accepted, idle randomly.
  always @(posedge clk_i) begin
    int unsigned g;
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(process_triangle(pending_tris.pop_front()));
      g = rand_gap();
      if (g == 0 && pending_tris.size() > 0) begin
        // Back to back: present the next item right away.
        {vertex_a_i, vertex_b_i, vertex_c_i, end_of_mesh_i} <= pending_tris[0];
      end else begin
        in_gap <= g;
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i && rst_ni) begin
      if (in_gap > 0) in_gap <= in_gap - 1;
      else if (pending_tris.size() > 0) begin
        in_valid_i <= 1'b1;
        {vertex_a_i, vertex_b_i, vertex_c_i, end_of_mesh_i} <= pending_tris[0];
      end
    end
  end

  // Monitor: random backpressure, compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    tri_result_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("unexpected result item %0d", results_seen);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (new_vertex_count_o !== want.new_vertex_count)
          report_mismatch("new_vertex_count", new_vertex_count_o, want.new_vertex_count);
        if (flush_done_o !== want.flush_done)
          report_mismatch("flush_done", flush_done_o, want.flush_done);
        if (transformed_total_o !== want.transformed_total)
          report_mismatch("transformed_total", transformed_total_o, want.transformed_total);
        if (warps_total_o !== want.warps_total)
          report_mismatch("warps_total", warps_total_o, want.warps_total);
        if (run_end_o !== want.run_end)
          report_mismatch("run_end", run_end_o, want.run_end);
        flushes_seen += want.flush_done;
        meshes_seen += want.run_end;
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (out_valid_o && out_ready_i) out_gap <= rand_gap();
    end
  end

  // Watchdog: end the run if no item moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni || stim_done)
      idle_cycles <= 0;
    else if (pending_tris.size() > 0 || expected_results.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgCacheDepth: depth_q = data[6:0];
      CfgWarpLimit:  warp_lim_q = data[7:0];
      default:       batch_lim_q = data;
    endcase
  endtask

  // Wait until every result has come back, then let the pipeline settle.
  task automatic drain();
    int unsigned n;
    n = 0;
    while ((pending_tris.size() > 0 || in_valid_i || expected_results.size() > 0)
           && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic item_t make_tri(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                     logic eom);
    item_t t;
    t.vertex_a = a; t.vertex_b = b; t.vertex_c = c; t.end_of_mesh = eom;
    return t;
  endfunction

  // Mesh-like index: mostly near a sliding base so the cache sees reuse.
  function automatic logic [31:0] pick_index(logic [31:0] base);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return base + $urandom_range(0, 12);
    if (r < 90) return $urandom();
    return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom_range(0, 3))};
  endfunction

  task automatic random_phase(int unsigned count);
    logic [31:0] base, a;
    base = $urandom_range(0, 1000);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) base += $urandom_range(1, 4);
      a = pick_index(base);
      pending_tris.push_back(make_tri(a, $urandom_range(0, 7) == 0 ? a : pick_index(base),
                                      pick_index(base), $urandom_range(0, 39) == 0));
    end
    pending_tris.push_back(make_tri(pick_index(base), pick_index(base), pick_index(base), 1'b1));
    drain();
  endtask

  initial begin
    clear_mesh();
    for (int k = 0; k < MaxCacheDepth; k++) slot_vertex[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset config, extreme indices, duplicates, reuse, end of mesh.
    pending_tris.push_back(make_tri('0, '1, 32'hAAAA_5555, 1'b0));
    pending_tris.push_back(make_tri(32'h5555_AAAA, '0, '1, 1'b0));
    pending_tris.push_back(make_tri(7, 7, 7, 1'b0));
    pending_tris.push_back(make_tri(7, 8, 7, 1'b0));
    pending_tris.push_back(make_tri(1, 2, 3, 1'b1));
    pending_tris.push_back(make_tri(1, 2, 3, 1'b1));
    drain();

    // Zero depth: every vertex misses; warp limit of 1 with a batch limit of 2.
    write_cfg(CfgCacheDepth, 16'd0);
    write_cfg(CfgWarpLimit, 16'd1);
    write_cfg(CfgBufLimit, 16'd2);
    for (int i = 0; i < 6; i++) pending_tris.push_back(make_tri(i, i, i + 1, i == 5));
    drain();

    // Depth above the maximum, small depths, and the widest register values.
    write_cfg(CfgCacheDepth, 16'd127);
    write_cfg(CfgWarpLimit, 16'd255);
    write_cfg(CfgBufLimit, 16'hFFFF);
    random_phase(120);
    write_cfg(CfgCacheDepth, 16'd1);
    write_cfg(CfgWarpLimit, 16'd2);
    write_cfg(CfgBufLimit, 16'd0);
    random_phase(80);
    write_cfg(CfgCacheDepth, 16'd2);
    write_cfg(CfgWarpLimit, 16'd0);
    write_cfg(CfgBufLimit, 16'd3);
    random_phase(80);
    write_cfg(CfgCacheDepth, 16'd3);
    write_cfg(CfgWarpLimit, 16'd12);
    write_cfg(CfgBufLimit, 16'd16);
    random_phase(140);
    write_cfg(CfgCacheDepth, 16'd64);
    write_cfg(CfgWarpLimit, 16'd64);
    write_cfg(CfgBufLimit, 16'd40);
    random_phase(140);
    for (int p = 0; p < 2; p++) begin
      write_cfg(CfgCacheDepth, 16'($urandom_range(0, 127)));
      write_cfg(CfgWarpLimit, 16'($urandom_range(0, 255)));
      write_cfg(CfgBufLimit, 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 30)));
      random_phase(70);
    end

    stim_done = 1;
    $display("covered %0d results, %0d flushes, %0d mesh ends over several cache settings",
             results_seen, flushes_seen, meshes_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
